### hdl/bqlp_pkg.sv
`timescale 1ns / 1ps
package bqlp_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int TABLE_ROWS    = 11;
    localparam int C_BASE_SHIFT  = 29;
    localparam int C_RADIX_BITS  = 3;
    localparam int FILTERED_BITS = 18;
    localparam int COEF_BITS     = 27;
    localparam int HIST_BITS     = 32;
    localparam int XSUM_BITS     = SAMPLE_BITS + 4;
    localparam int ACC_BITS      = 62;
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 16;

    typedef logic [SAMPLE_BITS-1:0]          t_sample;
    typedef logic signed [FILTERED_BITS-1:0] t_filtered;
    typedef logic signed [COEF_BITS-1:0]     t_coef;
    typedef logic signed [HIST_BITS-1:0]     t_hist;
    typedef logic [4:0]                      t_shift;
    typedef logic [3:0]                      t_cutoff;
    typedef logic [15:0]                     t_in_max;
    typedef logic [CFG_IDX_BITS-1:0]         t_cfg_idx;
    typedef logic [CFG_DATA_BITS-1:0]        t_cfg_data;

    typedef struct packed {
        t_coef  gain;
        t_coef  coeff1;
        t_coef  coeff2;
        t_shift shift;
    } t_coef_set;

    localparam t_cfg_idx C_REG_CUTOFF = 4'd0;
    localparam t_cfg_idx C_REG_IN_MAX = 4'd1;

    localparam t_cutoff C_CUTOFF_RESET = 4'd0;
    localparam t_in_max C_IN_MAX_RESET = 16'd4095;

    // gain, coeff1, coeff2 per cutoff row; rows five and six are identical
    localparam logic signed [31:0] C_ROM [TABLE_ROWS][3] = '{
        '{32'sd507178,   32'sd1026066113, -32'sd491223911},
        '{32'sd1944375,  32'sd978551887,  -32'sd449458477},
        '{32'sd4198442,  32'sd931323806,  -32'sd411246662},
        '{32'sd7172166,  32'sd884473343,  -32'sd376291094},
        '{32'sd10782175, 32'sd838065198,  -32'sd344322985},
        '{32'sd14957098, 32'sd792142531,  -32'sd315100012},
        '{32'sd14957098, 32'sd792142531,  -32'sd315100012},
        '{32'sd19635965, 32'sd746731218,  -32'sd288404168},
        '{32'sd24766823, 32'sd701843306,  -32'sd264039684},
        '{32'sd30305537, 32'sd657479811,  -32'sd241831049},
        '{32'sd36214774, 32'sd613632985,  -32'sd221621170}
    };

    function automatic t_coef_set f_derive(input t_cutoff sel, input t_in_max max_val);
        t_cutoff           row;
        logic [4:0]        b;
        logic [4:0]        bf;
        logic signed [31:0] g;
        logic signed [31:0] c1;
        logic signed [31:0] c2;
        t_coef_set         res;
        row = (sel > 4'(TABLE_ROWS - 1)) ? 4'(TABLE_ROWS - 1) : sel;
        b = 5'd1;
        for (int i = 1; i < 16; i++) begin
            if (max_val[i]) begin
                b = 5'(i + 1);
            end
        end
        bf = b + 5'(C_RADIX_BITS);
        g  = (C_ROM[row][0] + (32'sd1 <<< (b - 5'd1))) >>> b;
        c1 = (C_ROM[row][1] + (32'sd1 <<< (bf - 5'd1))) >>> bf;
        c2 = (C_ROM[row][2] + (32'sd1 <<< (bf - 5'd1))) >>> bf;
        res.gain   = t_coef'(g);
        res.coeff1 = t_coef'(c1);
        res.coeff2 = t_coef'(c2);
        res.shift  = 5'(C_BASE_SHIFT) - bf;
        return res;
    endfunction

endpackage

### hdl/bqlp_if.sv
`timescale 1ns / 1ps
interface bqlp_sample_if;
    logic               valid;
    logic               ready;
    bqlp_pkg::t_sample  sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface bqlp_filtered_if;
    logic                 valid;
    logic                 ready;
    bqlp_pkg::t_filtered  filtered;
    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

interface bqlp_cfg_if;
    logic                 valid;
    logic                 ready;
    bqlp_pkg::t_cfg_idx   index;
    bqlp_pkg::t_cfg_data  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/biquad_lowpass_filter_top.sv
`timescale 1ns / 1ps
// Second-order Butterworth low-pass biquad on an unsigned 16-bit sample stream. One sample
// word is taken per clock while the output register is empty or being drained; its
// filtered word is written into the output register at the edge that accepts the sample.
// Throughput is one word per cycle while the output is drained, set by the combinational
// feedback path (three multipliers and an adder tree feeding the output history). The
// input side keeps taking words while a result waits, as long as the output register is
// being drained. A write to the cutoff row or the input-maximum register rescales the
// coefficients at the write edge and applies to the next accepted sample; the histories are kept.
module biquad_lowpass_filter_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    bqlp_cfg_if.sink            i_cfg,
    bqlp_sample_if.sink         i_sample,
    bqlp_filtered_if.source     o_filtered
);
    import bqlp_pkg::*;

    t_cutoff   r_cutoff;
    t_in_max   r_in_max;
    t_cutoff   n_cutoff;
    t_in_max   n_in_max;
    logic      cfg_hit;
    t_coef_set r_coef;

    t_sample   r_x0;
    t_sample   r_x1;
    t_hist     r_y0;
    t_hist     r_y1;

    logic      r_out_valid;
    t_filtered r_filtered;

    logic                         in_fire;
    logic [XSUM_BITS-1:0]         xsum;
    logic signed [XSUM_BITS+COEF_BITS-1:0] prod_x;
    logic signed [HIST_BITS+COEF_BITS-1:0] prod_y1;
    logic signed [HIST_BITS+COEF_BITS-1:0] prod_y0;
    logic signed [ACC_BITS-1:0]   acc;
    logic signed [ACC_BITS-1:0]   acc_sh;
    t_hist                        y_new;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cutoff = r_cutoff;
        n_in_max = r_in_max;
        cfg_hit  = 1'b0;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                C_REG_CUTOFF: begin
                    n_cutoff = i_cfg.data[3:0];
                    cfg_hit  = 1'b1;
                end
                C_REG_IN_MAX: begin
                    n_in_max = i_cfg.data;
                    cfg_hit  = 1'b1;
                end
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= C_CUTOFF_RESET;
            r_in_max <= C_IN_MAX_RESET;
            r_coef   <= f_derive(C_CUTOFF_RESET, C_IN_MAX_RESET);
        end else if (cfg_hit) begin
            r_cutoff <= n_cutoff;
            r_in_max <= n_in_max;
            r_coef   <= f_derive(n_cutoff, n_in_max);
        end
    end

    assign i_sample.ready = !r_out_valid || o_filtered.ready;
    assign in_fire        = i_sample.valid && i_sample.ready;

    // x2 + 2*x1 + x0, always non-negative
    assign xsum    = XSUM_BITS'(r_x1) + XSUM_BITS'({r_x0, 1'b0})
                   + XSUM_BITS'(i_sample.sample);
    assign prod_x  = $signed(xsum) * r_coef.gain;
    assign prod_y1 = r_y1 * r_coef.coeff2;
    assign prod_y0 = r_y0 * r_coef.coeff1;
    assign acc     = ACC_BITS'(prod_x) + ACC_BITS'(prod_y1) + ACC_BITS'(prod_y0);
    assign acc_sh  = acc >>> r_coef.shift;
    assign y_new   = acc_sh[HIST_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x0 <= '0;
            r_x1 <= '0;
            r_y0 <= '0;
            r_y1 <= '0;
        end else if (in_fire) begin
            r_x1 <= r_x0;
            r_x0 <= i_sample.sample;
            r_y1 <= r_y0;
            r_y0 <= y_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_filtered.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // take bits [20:3] of the wrapped internal output
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_filtered <= y_new[FILTERED_BITS+C_RADIX_BITS-1:C_RADIX_BITS];
        end
    end

    assign o_filtered.valid    = r_out_valid;
    assign o_filtered.filtered = r_filtered;

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_out_valid)
        else $error("accepted sample produced no result word");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_sample.ready)
        else $error("input stalled with empty output register");

    a_history_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_x1 == $past(r_x0)) && (r_y1 == $past(r_y0)))
        else $error("history did not advance on accepted sample");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_coef.shift >= 5'd10) && (r_coef.shift <= 5'd25))
        else $error("output shift out of range");

    a_drain_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_filtered.ready && !in_fire) |=> !r_out_valid)
        else $error("result word repeated after it was taken");

endmodule

### dv/tb_biquad_lowpass_filter_top.sv
`timescale 1ns / 1ps
module tb_biquad_lowpass_filter_top;
    import bqlp_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 6;
    localparam int STALL_LIMIT  = 4000;
    localparam int SEGMENTS     = 9;
    localparam int SEG_ITEMS    = 222;
    localparam int PRINT_CAP    = 100;

    localparam t_cfg_idx REG_SPARE_LOW = 4'd2;
    localparam t_cfg_idx REG_SPARE_TOP = 4'd15;

    typedef enum logic {STEP_SAMPLE, STEP_WRITE} t_step_kind;

    typedef struct packed {
        t_step_kind kind;
        t_cfg_idx   idx;
        t_cfg_data  word;
        logic       pinned;
        t_filtered  want;
    } t_step;

    typedef struct packed {
        int unsigned ord;
        t_filtered   val;
    } t_pinned;

    // idx is don't-care on sample rows; word carries the sample there
    localparam t_step DIRECTED [29] = '{
        '{STEP_SAMPLE, '0,            16'd0,     1'b1, 18'sd0},
        '{STEP_SAMPLE, '0,            16'd0,     1'b1, 18'sd0},
        '{STEP_SAMPLE, '0,            16'd65535, 1'b1, 18'sd61},
        '{STEP_SAMPLE, '0,            16'd65535, 1'b0, 18'sd0},
        '{STEP_SAMPLE, '0,            16'd65535, 1'b0, 18'sd0},
        '{STEP_SAMPLE, '0,            16'd0,     1'b0, 18'sd0},
        '{STEP_SAMPLE, '0,            16'd0,     1'b0, 18'sd0},
        '{STEP_WRITE,  C_REG_IN_MAX,  16'hFFFF,  1'b0, 18'sd0},
        '{STEP_WRITE,  C_REG_CUTOFF,  16'd10,    1'b0, 18'sd0},
        '{STEP_SAMPLE, '0,            16'd65535, 1'b0, 18'sd0},
        '{STEP_SAMPLE, '0,            16'd65535, 1'b0, 18'sd0},
        '{STEP_SAMPLE, '0,            16'd0,     1'b0, 18'sd0},
        '{STEP_WRITE,  C_REG_CUTOFF,  16'hFFFF,  1'b0, 18'sd0},
        '{STEP_SAMPLE, '0,            16'd40000, 1'b0, 18'sd0},
        '{STEP_SAMPLE, '0,            16'd65535, 1'b0, 18'sd0},
        '{STEP_WRITE,  C_REG_IN_MAX,  16'd0,     1'b0, 18'sd0},
        '{STEP_WRITE,  C_REG_CUTOFF,  16'd5,     1'b0, 18'sd0},
        '{STEP_SAMPLE, '0,            16'd65535, 1'b0, 18'sd0},
        '{STEP_SAMPLE, '0,            16'd65535, 1'b0, 18'sd0},
        '{STEP_WRITE,  C_REG_CUTOFF,  16'd6,     1'b0, 18'sd0},
        '{STEP_SAMPLE, '0,            16'd0,     1'b0, 18'sd0},
        '{STEP_SAMPLE, '0,            16'd65535, 1'b0, 18'sd0},
        '{STEP_WRITE,  REG_SPARE_LOW, 16'hA5A5,  1'b0, 18'sd0},
        '{STEP_WRITE,  REG_SPARE_TOP, 16'hFFFF,  1'b0, 18'sd0},
        '{STEP_SAMPLE, '0,            16'd1,     1'b0, 18'sd0},
        '{STEP_SAMPLE, '0,            16'd32768, 1'b0, 18'sd0},
        '{STEP_WRITE,  C_REG_IN_MAX,  16'd1,     1'b0, 18'sd0},
        '{STEP_SAMPLE, '0,            16'd65535, 1'b0, 18'sd0},
        '{STEP_SAMPLE, '0,            16'd0,     1'b0, 18'sd0}
    };

    logic i_clk;
    logic i_rst_n;

    bqlp_cfg_if      cfg_bus ();
    bqlp_sample_if   smp_bus ();
    bqlp_filtered_if flt_bus ();

    biquad_lowpass_filter_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg_bus),
        .i_sample   (smp_bus),
        .o_filtered (flt_bus)
    );

    // filter model state
    t_cutoff            cut_sel;
    t_in_max            in_max;
    longint             tap_gain;
    longint             tap_fb1;
    longint             tap_fb2;
    int                 post_shift;
    t_sample            x_hist [2];
    logic signed [31:0] y_hist [2];

    t_filtered   filtered_due [$];
    t_pinned     pinned_due [$];
    int unsigned sent_count;
    int unsigned taken_count;
    int unsigned err_count;
    int          send_gap_pct;
    int          recv_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic void rescale_taps();
        int unsigned row;
        int          bits;
        row  = (cut_sel > TABLE_ROWS - 1) ? TABLE_ROWS - 1 : cut_sel;
        bits = 1;
        while (bits < 16 && (in_max >> bits) != 0) bits++;
        tap_gain = (longint'(C_ROM[row][0]) + (longint'(1) << (bits - 1))) >>> bits;
        bits += C_RADIX_BITS;
        tap_fb1 = (longint'(C_ROM[row][1]) + (longint'(1) << (bits - 1))) >>> bits;
        tap_fb2 = (longint'(C_ROM[row][2]) + (longint'(1) << (bits - 1))) >>> bits;
        post_shift = (C_BASE_SHIFT - bits) & 31;
    endfunction

    function automatic t_filtered lowpass_step(input t_sample x0);
        longint      xsum;
        longint      acc;
        logic [31:0] y;
        xsum = longint'(x_hist[1]) + 2 * longint'(x_hist[0]) + longint'(x0);
        acc  = xsum * tap_gain + tap_fb2 * longint'(y_hist[1])
               + tap_fb1 * longint'(y_hist[0]);
        // wrap to 32 bits before it feeds back
        y = 32'(acc >>> post_shift);
        x_hist[1] = x_hist[0];
        x_hist[0] = x0;
        y_hist[1] = y_hist[0];
        y_hist[0] = y;
        return t_filtered'(y[20:3]);
    endfunction

    task automatic flag_mismatch(input string what);
        if (err_count < PRINT_CAP) $display("MISMATCH @%0t: %s", $realtime, what);
        err_count++;
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_filtered want;
        if (!i_rst_n) begin
            cut_sel   = C_CUTOFF_RESET;
            in_max    = C_IN_MAX_RESET;
            x_hist[0] = '0;
            x_hist[1] = '0;
            y_hist[0] = '0;
            y_hist[1] = '0;
            rescale_taps();
        end else begin
            if (cfg_bus.valid && cfg_bus.ready) begin
                if (cfg_bus.index == C_REG_CUTOFF) begin
                    cut_sel = cfg_bus.data[3:0];
                    rescale_taps();
                end else if (cfg_bus.index == C_REG_IN_MAX) begin
                    in_max = cfg_bus.data;
                    rescale_taps();
                end
            end
            if (smp_bus.valid && smp_bus.ready) begin
                want = lowpass_step(smp_bus.sample);
                if (pinned_due.size() != 0 && pinned_due[0].ord == taken_count) begin
                    want = pinned_due[0].val;
                    void'(pinned_due.pop_front());
                end
                filtered_due.push_back(want);
                taken_count++;
            end
            if (flt_bus.valid && flt_bus.ready) begin
                if (filtered_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected word filtered=%0d", flt_bus.filtered));
                end else begin
                    want = filtered_due.pop_front();
                    if (flt_bus.filtered !== want)
                        flag_mismatch($sformatf("filtered got %0d want %0d",
                                                flt_bus.filtered, want));
                end
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((cfg_bus.valid && cfg_bus.ready) || (smp_bus.valid && smp_bus.ready)
                    || (flt_bus.valid && flt_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : receiver
        flt_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            flt_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // drop sample valid and hold until every word in flight has come back
    task automatic drain();
        smp_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (filtered_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic push_sample(input t_sample val);
        sent_count++;
        if ($urandom_range(149) == 0) drain();
        if ($urandom_range(99) < send_gap_pct) begin
            smp_bus.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_gap_pct);
        end
        smp_bus.valid  <= 1'b1;
        smp_bus.sample <= val;
        do @(posedge i_clk); while (!(smp_bus.valid && smp_bus.ready));
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data val);
        drain();
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge i_clk); while (!(cfg_bus.valid && cfg_bus.ready));
        cfg_bus.valid <= 1'b0;
    endtask

    initial begin : stimulus
        t_cutoff seg_cut;
        t_in_max seg_max;
        t_sample val;
        int      seg_sent;
        int      run_len;
        int      run_kind;
        i_rst_n        <= 1'b0;
        smp_bus.valid  <= 1'b0;
        smp_bus.sample <= '0;
        cfg_bus.valid  <= 1'b0;
        cfg_bus.index  <= '0;
        cfg_bus.data   <= '0;
        sent_count     = 0;
        taken_count    = 0;
        err_count      = 0;
        send_gap_pct   = 37;
        recv_stall_pct = 54;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].kind == STEP_WRITE) begin
                write_reg(DIRECTED[r].idx, DIRECTED[r].word);
            end else begin
                if (DIRECTED[r].pinned) pinned_due.push_back('{sent_count, DIRECTED[r].want});
                push_sample(DIRECTED[r].word);
            end
        end

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg < 3) begin
                send_gap_pct   = 37;
                recv_stall_pct = 54;
            end else if (seg < 6) begin
                send_gap_pct   = 54;
                recv_stall_pct = 37;
            end else begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            seg_cut = 4'($urandom_range(15));
            seg_max = 16'($urandom) >> $urandom_range(15);
            if (seg == 0) begin
                seg_cut = 4'd0;
                seg_max = 16'hFFFF;
            end else if (seg == 1) begin
                seg_cut = 4'd10;
                seg_max = 16'd0;
            end else if (seg == 2) begin
                seg_cut = 4'd15;
            end
            write_reg(C_REG_CUTOFF, {12'($urandom), seg_cut});
            write_reg(C_REG_IN_MAX, seg_max);
            if ($urandom_range(2) == 0)
                write_reg(t_cfg_idx'($urandom_range(REG_SPARE_TOP, REG_SPARE_LOW)),
                          16'($urandom));

            seg_sent = 0;
            while (seg_sent < SEG_ITEMS) begin
                // steps and holds mostly, with runs of raw noise between them
                run_kind = $urandom_range(7);
                run_len  = $urandom_range(1, 24);
                case (run_kind)
                    0:       val = '0;
                    1:       val = 16'hFFFF;
                    2, 3, 4: val = t_sample'($urandom_range(seg_max));
                    default: val = 16'($urandom);
                endcase
                for (int k = 0; k < run_len && seg_sent < SEG_ITEMS; k++) begin
                    if (run_kind > 4) val = 16'($urandom);
                    push_sample(val);
                    seg_sent++;
                end
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (filtered_due.size() != 0)
            flag_mismatch($sformatf("%0d filtered words never came", filtered_due.size()));
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### filelist.f
hdl/bqlp_pkg.sv
hdl/bqlp_if.sv
hdl/biquad_lowpass_filter_top.sv
dv/tb_biquad_lowpass_filter_top.sv
